>>> rtl/rbpc_pkg.sv
// Shared widths, operation codes and types of the ring buffer with peek and commit.
`timescale 1ns / 1ps

package rbpc_pkg;

    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int FRAMES_W  = 7;
    localparam int PTR_IN_W  = 12;

    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_RD  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_WR  = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0]   sample_out;
        logic                sample_valid;
        logic [FRAMES_W-1:0] granted_frames;
        logic                last;
    } t_result;

    // Status of the output queue as seen by the sequencer.
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PEEK = 3'b010,
        S_MOD  = 3'b100
    } t_state;

endpackage

>>> rtl/rbpc_if.sv
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps

interface rbpc_in_if import rbpc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [DATA_W-1:0]   sample_in;
    logic [FRAMES_W-1:0] frames;
    logic [PTR_IN_W-1:0] pointer_value;

    modport source (output valid, operation, sample_in, frames, pointer_value, input ready);
    modport sink   (input valid, operation, sample_in, frames, pointer_value, output ready);
endinterface

interface rbpc_out_if import rbpc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   sample_out;
    logic                sample_valid;
    logic [FRAMES_W-1:0] granted_frames;
    logic                last;

    modport source (output valid, sample_out, sample_valid, granted_frames, last, input ready);
    modport sink   (input valid, sample_out, sample_valid, granted_frames, last, output ready);
endinterface

>>> rtl/rbpc_store.sv
// Sample memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module rbpc_store import rbpc_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int SW    = 32,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [SW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [SW-1:0] o_rd_data
);

    logic [SW-1:0] r_mem [DEPTH];
    logic [SW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/rbpc_out_fifo.sv
// Two-entry result queue that decouples the sequencer from the result receiver.
`timescale 1ns / 1ps

module rbpc_out_fifo import rbpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_push_data,
    output t_fifo_stat o_stat,
    rbpc_out_if.source o_out
);

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;
    t_result    head;

    assign pop  = o_out.valid & o_out.ready;
    assign head = r_mem[r_rp];

    assign o_out.valid          = (r_cnt != 2'd0);
    assign o_out.sample_out     = head.sample_out;
    assign o_out.sample_valid   = head.sample_valid;
    assign o_out.granted_frames = head.granted_frames;
    assign o_out.last           = head.last;

    assign o_stat.count = r_cnt;
    assign o_stat.pop   = pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |-> !i_push)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt == 2'd0 || r_cnt == 2'd1))
        else $error("result queue count jumped from empty");

endmodule

>>> rtl/rbpc_ctrl.sv
// Sequencer: pointers, availability check, peek read streaming, pointer reduction.
`timescale 1ns / 1ps

module rbpc_ctrl import rbpc_pkg::*; #(
    parameter int DEPTH     = 4096,
    parameter int MAX_BLOCK = 64,
    parameter int SW        = 32,
    parameter int AW        = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rbpc_in_if.sink       i_in,
    input  t_fifo_stat    i_fifo,
    output logic          o_push,
    output t_result       o_push_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [SW-1:0] o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [SW-1:0] i_rd_data
);

    localparam int  CW        = (AW > FRAMES_W) ? AW : FRAMES_W;
    localparam int  MOD_STEPS = 3;
    localparam int  STEP_W    = 2;
    localparam bit  NEED_MOD  = (DEPTH < (2 ** PTR_IN_W));
    localparam int  MOD_D     = NEED_MOD ? DEPTH : 1;
    localparam int  RECIP_SH  = 24;
    localparam int  PROD_W    = PTR_IN_W + RECIP_SH;
    localparam int  RECIP     = (1 << RECIP_SH) / MOD_D;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_wp, n_wp;
    logic [AW-1:0]       r_rp, n_rp;
    logic                r_rd_pend;
    logic [AW-1:0]       r_addr, n_addr;
    logic [FRAMES_W-1:0] r_idx, n_idx;
    logic [FRAMES_W-1:0] r_n, n_n;
    logic                r_pend_last, n_pend_last;
    logic [FRAMES_W-1:0] r_pend_n, n_pend_n;
    logic [PTR_IN_W-1:0] r_rem, n_rem;
    logic [PTR_IN_W-1:0] r_quot, n_quot;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_sel_wr, n_sel_wr;

    logic                in_fire;
    logic                slot_ok;
    logic [FRAMES_W-1:0] n_sat;
    logic [AW:0]         avail_x;
    logic [AW-1:0]       avail;
    logic                enough;
    logic [CW:0]         adv_sum;
    logic [AW-1:0]       adv_rp;
    logic [AW-1:0]       wp_inc;
    logic [AW-1:0]       addr_inc;
    logic                issue_last;
    logic [PROD_W-1:0]   quot_prod;
    logic [PTR_IN_W-1:0] quot_est;
    logic [PTR_IN_W-1:0] rem_diff;
    logic [PTR_IN_W-1:0] rem_next;
    t_result             direct;
    logic                direct_push;

    // Room for one more beat once everything in flight has landed.
    assign slot_ok = ({1'b0, i_fifo.count} + 3'(r_rd_pend)) <= (3'd1 + 3'(i_fifo.pop));

    assign i_in.ready = (r_state == S_IDLE) & ~r_rd_pend & slot_ok;
    assign in_fire    = i_in.valid & i_in.ready;

    assign n_sat = (i_in.frames > FRAMES_W'(MAX_BLOCK)) ? FRAMES_W'(MAX_BLOCK) : i_in.frames;

    // Equal pointers mean empty, so a full buffer reads as empty.
    assign avail_x = (r_wp >= r_rp) ? ({1'b0, r_wp} - {1'b0, r_rp})
                                    : ((AW+1)'(DEPTH) - {1'b0, r_rp} + {1'b0, r_wp});
    assign avail   = avail_x[AW-1:0];
    assign enough  = CW'(avail) >= CW'(n_sat);

    // Granted frames never exceed avail < DEPTH, so one subtract wraps the sum.
    assign adv_sum = (CW+1)'(r_rp) + (CW+1)'(n_sat);
    assign adv_rp  = (adv_sum >= (CW+1)'(DEPTH)) ? AW'(adv_sum - (CW+1)'(DEPTH)) : AW'(adv_sum);

    assign wp_inc   = (({1'b0, r_wp} + 1'b1) == (AW+1)'(DEPTH)) ? '0 : r_wp + 1'b1;
    assign addr_inc = (({1'b0, r_addr} + 1'b1) == (AW+1)'(DEPTH)) ? '0 : r_addr + 1'b1;

    assign issue_last = ((r_idx + 1'b1) == r_n);

    // Reciprocal remainder: the quotient estimate is low by at most one,
    // so a single compare and subtract finishes the reduction.
    assign quot_prod = PROD_W'(r_rem) * PROD_W'(RECIP);
    assign quot_est  = quot_prod[PROD_W-1:RECIP_SH];
    assign rem_diff  = r_rem - PTR_IN_W'(r_quot * PTR_IN_W'(MOD_D));
    assign rem_next  = (r_rem >= PTR_IN_W'(MOD_D)) ? (r_rem - PTR_IN_W'(MOD_D)) : r_rem;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_n         = r_n;
        n_pend_last = r_pend_last;
        n_pend_n    = r_pend_n;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_step      = r_step;
        n_sel_wr    = r_sel_wr;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        direct_push = 1'b0;
        direct      = '{sample_out: '0, sample_valid: 1'b0, granted_frames: '0, last: 1'b1};

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in.operation)
                        OP_WRITE: begin
                            o_wr_en = 1'b1;
                            n_wp    = wp_inc;
                        end
                        OP_PEEK: begin
                            if (enough && n_sat != '0) begin
                                n_state = S_PEEK;
                                n_addr  = r_rp;
                                n_idx   = '0;
                                n_n     = n_sat;
                            end else begin
                                direct_push = 1'b1;
                            end
                        end
                        OP_ADVANCE: begin
                            direct_push = 1'b1;
                            if (enough) begin
                                n_rp                  = adv_rp;
                                direct.granted_frames = n_sat;
                            end
                        end
                        OP_SET_RD, OP_SET_WR: begin
                            if (NEED_MOD) begin
                                n_state  = S_MOD;
                                n_rem    = i_in.pointer_value;
                                n_step   = STEP_W'(MOD_STEPS - 1);
                                n_sel_wr = (i_in.operation == OP_SET_WR);
                            end else if (i_in.operation == OP_SET_WR) begin
                                n_wp = AW'(i_in.pointer_value);
                            end else begin
                                n_rp = AW'(i_in.pointer_value);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PEEK: begin
                if (slot_ok) begin
                    o_rd_en     = 1'b1;
                    n_addr      = addr_inc;
                    n_idx       = r_idx + 1'b1;
                    n_pend_last = issue_last;
                    n_pend_n    = r_n;
                    if (issue_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MOD: begin
                n_step = r_step - 1'b1;
                if (r_step == STEP_W'(2)) begin
                    n_quot = quot_est;
                end else if (r_step == STEP_W'(1)) begin
                    n_rem = rem_diff;
                end else begin
                    n_state = S_IDLE;
                    if (r_sel_wr) begin
                        n_wp = AW'(rem_next);
                    end else begin
                        n_rp = AW'(rem_next);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_addr = r_wp;
    assign o_wr_data = SW'(i_in.sample_in);
    assign o_rd_addr = r_addr;

    // A returning read and a direct result never meet: ready waits out the read.
    assign o_push = r_rd_pend | direct_push;
    always_comb begin
        if (r_rd_pend) begin
            o_push_data = '{sample_out: DATA_W'(i_rd_data), sample_valid: 1'b1,
                            granted_frames: r_pend_n, last: r_pend_last};
        end else begin
            o_push_data = direct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_rd_pend <= o_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_idx       <= n_idx;
        r_n         <= n_n;
        r_pend_last <= n_pend_last;
        r_pend_n    <= n_pend_n;
        r_rem       <= n_rem;
        r_quot      <= n_quot;
        r_step      <= n_step;
        r_sel_wr    <= n_sel_wr;
    end

    a_peek_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_en && issue_last) |=> (r_state == S_IDLE))
        else $error("peek did not end after its last read");

    a_mod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_step == '0) |=> ((AW+1)'(r_sel_wr ? r_wp : r_rp) < (AW+1)'(DEPTH)))
        else $error("reduced pointer out of range");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_fifo.count != 2'd2 || i_fifo.pop))
        else $error("result pushed into a full queue");

endmodule

>>> rtl/ring_buffer_peek_commit.sv
// Top level of the circular sample buffer with peek and commit.
//
// Requests enter on i_in (valid/ready); one beat carries an operation, a
// sample, a frame count and a pointer value. Results leave on o_out.
//   write:       stores one sample at the write pointer, no result.
//   peek N:      if N samples are available, streams N beats from the read
//                pointer without moving it, one per cycle while the result
//                queue has room; i_in stays busy through the N reads and the
//                returning read. Else one refused beat.
//                N of zero gives one empty beat.
//   advance N:   one beat with the granted count.
//   set pointer: loaded directly when DEPTH >= 4096; otherwise the value is
//                reduced modulo DEPTH by a reciprocal multiply and one
//                correcting subtract.
// Sample reads come from a single-port-read synchronous memory; a two-entry
// result queue lets the sequencer keep streaming while the receiver takes
// beats. When o_out stalls, the queue fills, the peek stream pauses and
// i_in.ready drops; nothing is lost. Frame counts above MAX_BLOCK saturate.
// Reset clears both pointers and the queue; memory contents are not cleared.
`timescale 1ns / 1ps

module ring_buffer_peek_commit import rbpc_pkg::*; #(
    parameter int DEPTH        = 4096,
    parameter int MAX_BLOCK    = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbpc_in_if.sink    i_in,
    rbpc_out_if.source o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_fifo_stat              fifo_stat;
    logic                    push;
    t_result                 push_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_data;

    rbpc_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK),
        .SW        (SAMPLE_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fifo      (fifo_stat),
        .o_push      (push),
        .o_push_data (push_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    rbpc_store #(
        .DEPTH (DEPTH),
        .SW    (SAMPLE_WIDTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rbpc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_stat      (fifo_stat),
        .o_out       (o_out)
    );

endmodule

>>> sim/ring_buffer_peek_commit_tb.sv
// Self-checking testbench for the ring buffer with peek and commit.
`timescale 1ns / 1ps

module ring_buffer_peek_commit_tb;
    import rbpc_pkg::*;

    localparam int RING_DEPTH   = 4096;
    localparam int MAX_FRAMES   = 64;
    localparam int RANDOM_ITEMS = 320;
    localparam int TAIL_CYCLES  = 16;
    localparam int TIMEOUT_NS   = 50_000_000;

    logic clk;
    logic rst_n;

    rbpc_in_if  in_if ();
    rbpc_out_if out_if ();

    ring_buffer_peek_commit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the buffer contents and pointers.
    logic [DATA_W-1:0]   shadow_mem [RING_DEPTH];
    bit                  shadow_written [RING_DEPTH];
    logic [PTR_IN_W-1:0] shadow_wr_ptr;
    logic [PTR_IN_W-1:0] shadow_rd_ptr;

    t_result expected_beats [$];

    int error_count;
    int accepted_items;
    int beats_checked;
    int peeks_granted;
    int peeks_refused;
    int advances_granted;

    bit tx_steady;
    bit rx_steady;
    int hold_off_left;
    int rx_stall_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ring_buffer_peek_commit_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    // Mostly short stalls, now and then a long one.
    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PTR_IN_W-1:0] fill_level();
        return shadow_wr_ptr - shadow_rd_ptr;
    endfunction

    // Number of leading written entries from the read pointer, up to n.
    function automatic int written_run(input int n);
        int i;
        i = 0;
        while (i < n && shadow_written[PTR_IN_W'(shadow_rd_ptr + PTR_IN_W'(i))])
            i++;
        return i;
    endfunction

    function automatic void push_beat(input logic [DATA_W-1:0] smp, input logic vld,
                                      input logic [FRAMES_W-1:0] granted, input logic lst);
        t_result r;
        r.sample_out     = smp;
        r.sample_valid   = vld;
        r.granted_frames = granted;
        r.last           = lst;
        expected_beats.push_back(r);
    endfunction

    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [DATA_W-1:0] smp,
                                            input logic [FRAMES_W-1:0] fr,
                                            input logic [PTR_IN_W-1:0] pv);
        int n;
        logic [PTR_IN_W-1:0] avail;
        logic [PTR_IN_W-1:0] idx;
        n = (fr > MAX_FRAMES) ? MAX_FRAMES : int'(fr);
        avail = fill_level();
        case (op)
            OP_WRITE: begin
                shadow_mem[shadow_wr_ptr]     = smp;
                shadow_written[shadow_wr_ptr] = 1'b1;
                shadow_wr_ptr                 = shadow_wr_ptr + 1'b1;
            end
            OP_PEEK: begin
                if (int'(avail) < n || n == 0) begin
                    push_beat('0, 1'b0, '0, 1'b1);
                    peeks_refused++;
                end else begin
                    for (int i = 0; i < n; i++) begin
                        idx = shadow_rd_ptr + PTR_IN_W'(i);
                        push_beat(shadow_mem[idx], 1'b1, FRAMES_W'(n), i == n - 1);
                    end
                    peeks_granted++;
                end
            end
            OP_ADVANCE: begin
                if (int'(avail) < n) begin
                    push_beat('0, 1'b0, '0, 1'b1);
                end else begin
                    shadow_rd_ptr = shadow_rd_ptr + PTR_IN_W'(n);
                    push_beat('0, 1'b0, FRAMES_W'(n), 1'b1);
                    advances_granted++;
                end
            end
            OP_SET_RD: shadow_rd_ptr = pv;
            OP_SET_WR: shadow_wr_ptr = pv;
            default: ;
        endcase
    endfunction

    // Offers one request beat and returns at the edge it is accepted.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] smp,
                                input logic [FRAMES_W-1:0] fr,
                                input logic [PTR_IN_W-1:0] pv);
        int gap;
        int n;
        int run;
        // a granted peek must only cover entries that were written
        if (op == OP_PEEK) begin
            n = (fr > MAX_FRAMES) ? MAX_FRAMES : int'(fr);
            if (n != 0 && n <= int'(fill_level())) begin
                run = written_run(n);
                if (run < n)
                    fr = FRAMES_W'(run);
            end
        end
        gap = (!tx_steady && $urandom_range(0, 99) < 30) ? pick_stall() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= op;
        in_if.sample_in     <= smp;
        in_if.frames        <= fr;
        in_if.pointer_value <= pv;
        do @(posedge clk); while (!in_if.ready);
        predict_request(op, smp, fr, pv);
        if (op <= OP_SET_WR)
            accepted_items++;
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: each beat against the oldest expectation.
    initial begin
        t_result exp_beat;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                beats_checked++;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat sample=%h vld=%b granted=%0d last=%b",
                        out_if.sample_out, out_if.sample_valid, out_if.granted_frames,
                        out_if.last));
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (out_if.sample_out !== exp_beat.sample_out)
                        report_mismatch($sformatf("sample_out %h, want %h",
                            out_if.sample_out, exp_beat.sample_out));
                    if (out_if.sample_valid !== exp_beat.sample_valid)
                        report_mismatch($sformatf("sample_valid %b, want %b",
                            out_if.sample_valid, exp_beat.sample_valid));
                    if (out_if.granted_frames !== exp_beat.granted_frames)
                        report_mismatch($sformatf("granted_frames %0d, want %0d",
                            out_if.granted_frames, exp_beat.granted_frames));
                    if (out_if.last !== exp_beat.last)
                        report_mismatch($sformatf("last %b, want %b",
                            out_if.last, exp_beat.last));
                end
            end
        end
    end

    // Receiver: random stalls, plus a long forced hold-off on request.
    initial begin
        out_if.ready  = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                out_if.ready <= 1'b0;
                hold_off_left--;
            end else if (rx_stall_left > 0) begin
                out_if.ready <= 1'b0;
                rx_stall_left--;
            end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
                out_if.ready  <= 1'b0;
                rx_stall_left = pick_stall() - 1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_state();
        // nothing stored yet: a one-frame peek is refused
        send_request(OP_PEEK, '0, 7'd1, '0);
    endtask

    task automatic test_write_peek_advance();
        send_request(OP_WRITE, 32'h0000_0000, '0, '0);
        send_request(OP_WRITE, 32'hFFFF_FFFF, 7'h7F, 12'hFFF);
        send_request(OP_WRITE, 32'hA5A5_5A5A, '0, '0);
        send_request(OP_PEEK, '0, 7'd3, '0);
        send_request(OP_PEEK, '0, 7'd0, '0);
        send_request(OP_PEEK, '0, 7'd4, '0);
        send_request(OP_ADVANCE, '0, 7'd2, '0);
        send_request(OP_ADVANCE, '0, 7'd5, '0);
        send_request(OP_PEEK, '0, 7'd1, '0);
    endtask

    task automatic test_pointer_wrap();
        send_request(OP_SET_WR, '0, '0, 12'd4094);
        send_request(OP_SET_RD, '0, '0, 12'hFFF);
        send_request(OP_WRITE, 32'h1234_5678, '0, '0);
        send_request(OP_WRITE, 32'h8000_0001, '0, '0);
        send_request(OP_WRITE, 32'h7FFF_FFFE, '0, '0);
        send_request(OP_PEEK, '0, 7'd2, '0);
    endtask

    task automatic test_full_reads_empty();
        // one short of full, then one write: pointers meet, level reads zero
        send_request(OP_SET_RD, '0, '0, 12'h800);
        send_request(OP_SET_WR, '0, '0, 12'h7FF);
        send_request(OP_WRITE, 32'hDEAD_BEEF, '0, '0);
        send_request(OP_PEEK, '0, 7'd1, '0);
    endtask

    task automatic test_frame_saturation();
        send_request(OP_SET_RD, '0, '0, 12'd0);
        send_request(OP_SET_WR, '0, '0, 12'd100);
        send_request(OP_ADVANCE, '0, 7'h7F, '0);
    endtask

    task automatic test_unused_opcodes();
        send_request(3'd5, $urandom, 7'($urandom), 12'($urandom));
        send_request(3'd6, $urandom, 7'($urandom), 12'($urandom));
        send_request(3'd7, $urandom, 7'($urandom), 12'($urandom));
    endtask

    task automatic test_backpressure();
        send_request(OP_SET_RD, '0, '0, shadow_wr_ptr);
        repeat (MAX_FRAMES) send_request(OP_WRITE, $urandom, 7'($urandom), 12'($urandom));
        // receiver holds off while a full-size peek and more requests pile up
        hold_off_left = 200;
        send_request(OP_PEEK, '0, 7'd64, '0);
        send_request(OP_PEEK, '0, 7'd10, '0);
        send_request(OP_WRITE, $urandom, '0, '0);
        send_request(OP_ADVANCE, '0, 7'd8, '0);
        send_request(OP_PEEK, '0, 7'd20, '0);
        send_request(OP_ADVANCE, '0, 7'd100, '0);
        while (hold_off_left > 0)
            @(posedge clk);
        wait_results_drained();
    endtask

    function automatic logic [FRAMES_W-1:0] pick_frames();
        int avail;
        int r;
        avail = int'(fill_level());
        r = $urandom_range(0, 99);
        if (r < 70)
            return FRAMES_W'($urandom_range(0, (avail < 24) ? avail + 1 : 24));
        if (r < 90)
            return FRAMES_W'($urandom_range(0, MAX_FRAMES));
        return FRAMES_W'($urandom_range(MAX_FRAMES + 1, 127));
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic test_random_traffic();
        int start_count;
        int burst;
        int kind;
        bit paused;
        logic [FRAMES_W-1:0] fr;
        logic [PTR_IN_W-1:0] pv;
        start_count = accepted_items;
        paused      = 1'b0;
        while (accepted_items < start_count + RANDOM_ITEMS) begin
            tx_steady = (accepted_items - start_count) < 80;
            rx_steady = tx_steady;
            if (!paused && accepted_items - start_count >= 250) begin
                wait_results_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // write burst, peek, then usually commit what was peeked
                burst = $urandom_range(1, 20);
                repeat (burst)
                    send_request(OP_WRITE, pick_sample(), 7'($urandom), 12'($urandom));
                fr = pick_frames();
                send_request(OP_PEEK, $urandom, fr, 12'($urandom));
                if ($urandom_range(0, 3) != 0)
                    send_request(OP_ADVANCE, $urandom, in_if.frames, 12'($urandom));
                else
                    send_request(OP_ADVANCE, $urandom, pick_frames(), 12'($urandom));
            end else if (kind == 6) begin
                case ($urandom_range(0, 2))
                    0: pv = 12'($urandom);
                    1: pv = shadow_rd_ptr + 12'($urandom_range(0, 8));
                    default: pv = shadow_wr_ptr - 12'($urandom_range(0, 30));
                endcase
                send_request(OP_SET_RD, $urandom, 7'($urandom), pv);
            end else if (kind == 7) begin
                case ($urandom_range(0, 2))
                    0: pv = 12'($urandom);
                    1: pv = shadow_wr_ptr + 12'($urandom_range(0, 8));
                    default: pv = shadow_rd_ptr + 12'($urandom_range(0, 30));
                endcase
                send_request(OP_SET_WR, $urandom, 7'($urandom), pv);
            end else if (kind == 8) begin
                send_request(3'($urandom), $urandom, 7'($urandom), 12'($urandom));
            end else begin
                send_request($urandom_range(0, 1) ? OP_PEEK : OP_ADVANCE, $urandom,
                             7'($urandom), 12'($urandom));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        rst_n               = 1'b0;
        in_if.valid         = 1'b0;
        in_if.operation     = '0;
        in_if.sample_in     = '0;
        in_if.frames        = '0;
        in_if.pointer_value = '0;
        shadow_wr_ptr       = '0;
        shadow_rd_ptr       = '0;
        error_count         = 0;
        accepted_items      = 0;
        beats_checked       = 0;
        peeks_granted       = 0;
        peeks_refused       = 0;
        advances_granted    = 0;
        tx_steady           = 1'b0;
        rx_steady           = 1'b0;
        hold_off_left       = 0;
        for (int i = 0; i < RING_DEPTH; i++)
            shadow_written[i] = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_write_peek_advance();
        test_pointer_wrap();
        test_full_reads_empty();
        test_frame_saturation();
        test_unused_opcodes();
        test_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      expected_beats.size()));

        $display("Covered %0d requests and %0d result beats, incl. wrap, full-as-empty,",
                 accepted_items, beats_checked);
        $display("saturation, unused codes and stalls; peeks granted %0d refused %0d, advances %0d",
                 peeks_granted, peeks_refused, advances_granted);
        if (error_count == 0) begin
            $display("ring_buffer_peek_commit_tb: clean");
        end else begin
            $display("ring_buffer_peek_commit_tb: errors");
        end
        $finish;
    end

endmodule
